// File: design/mfb_pkg.sv
package mfb_pkg;

  localparam int DISP_WIDTH_DEF  = 128;
  localparam int DISP_HEIGHT_DEF = 64;
  localparam int CELL_COLS_DEF   = 21;
  localparam int CELL_ROWS_DEF   = 8;
  localparam int CELL_WIDTH_DEF  = 6;

  localparam int STORE_DEPTH = 1024;

  localparam logic [2:0] F_CLEAR = 3'd0;
  localparam logic [2:0] F_PIXEL = 3'd1;
  localparam logic [2:0] F_HLINE = 3'd2;
  localparam logic [2:0] F_VLINE = 3'd3;
  localparam logic [2:0] F_RECT  = 3'd4;
  localparam logic [2:0] F_CHAR  = 3'd5;
  localparam logic [2:0] F_READ  = 3'd6;

  localparam logic [7:0] FIRST_CODE = 8'h20;
  localparam logic [7:0] LAST_CODE  = 8'h7E;

  // Five glyph columns per printable code, leftmost column in the top byte.
  localparam logic [39:0] GLYPH [95] = '{
    40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14, 40'h242A7F2A12,
    40'h2313086462, 40'h3649552250, 40'h0005030000, 40'h001C224100, 40'h0041221C00,
    40'h14083E0814, 40'h08083E0808, 40'h0050300000, 40'h0808080808, 40'h0060600000,
    40'h2010080402, 40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
    40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503, 40'h3649494936,
    40'h064949291E, 40'h0036360000, 40'h0056360000, 40'h0814224100, 40'h1414141414,
    40'h0041221408, 40'h0201510906, 40'h324979413E, 40'h7E1111117E, 40'h7F49494936,
    40'h3E41414122, 40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
    40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
    40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E, 40'h7F09090906, 40'h3E4151215E,
    40'h7F09192946, 40'h4649494931, 40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F,
    40'h3F4038403F, 40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
    40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040, 40'h0001020400,
    40'h2054545478, 40'h7F48444438, 40'h3844444420, 40'h384444487F, 40'h3854545418,
    40'h087E090102, 40'h0C5252523E, 40'h7F08040478, 40'h00447D4000, 40'h2040443D00,
    40'h7F10284400, 40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
    40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420, 40'h043F444020,
    40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C, 40'h4428102844, 40'h0C5050503C,
    40'h4464544C44, 40'h0008364100, 40'h00007F0000, 40'h0041360800, 40'h1008081008
  };

  function automatic logic [7:0] glyph_col(input logic [6:0] gi, input logic [2:0] c);
    logic [39:0] g;
    g = GLYPH[gi];
    return g[39 - 8 * c -: 8];
  endfunction

endpackage

// File: design/mono_framebuffer_text_draw.sv
// From acceptance to m_tvalid: a read fetches its byte, an unused code goes straight to the
// reply, a command that draws nothing passes setup, a character cell has setup and six
// full-byte writes, a clear walks the whole buffer; each then replies. Lines, rectangles and
// pixels: setup and reply plus one write per fully covered byte and a read and a write per
// partly covered byte (read-modify-write on the single memory port). One command at a time;
// s_tready returns the cycle after the result is loaded, later while an earlier result still
// waits. Reset: synchronous; a clearing pass then zeroes the buffer with s_tready held low until it finishes.
module mono_framebuffer_text_draw #(
  parameter int DISP_WIDTH  = mfb_pkg::DISP_WIDTH_DEF,
  parameter int DISP_HEIGHT = mfb_pkg::DISP_HEIGHT_DEF,
  parameter int CELL_COLS   = mfb_pkg::CELL_COLS_DEF,
  parameter int CELL_ROWS   = mfb_pkg::CELL_ROWS_DEF,
  parameter int CELL_WIDTH  = mfb_pkg::CELL_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // x_pos[7:0] y_pos[15:8] x_end[23:16] y_end[31:24] rect_width[39:32]
  // rect_height[47:40] color[48] char_code[56:49] text_col[64:57] text_row[72:65]
  // read_index[82:73], zero above.
  input  logic [87:0] s_tdata,
  // func[2:0].
  input  logic [2:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // read_data[7:0] status[8], zero above.
  output logic [15:0] m_tdata
);
  import mfb_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CLR   = 3'd1;
  localparam logic [2:0] S_SETUP = 3'd2;
  localparam logic [2:0] S_STEP  = 3'd3;
  localparam logic [2:0] S_MOD   = 3'd4;
  localparam logic [2:0] S_RDW   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  localparam logic [8:0] XMAX = 9'(DISP_WIDTH - 1);
  localparam logic [8:0] YMAX = 9'(DISP_HEIGHT - 1);

  // Unpacked command fields.
  logic [2:0] func;
  logic [7:0] x_pos, y_pos, x_end, y_end, rect_width, rect_height;
  logic       color_in;
  logic [7:0] char_code, text_col, text_row;
  logic [9:0] read_index;

  assign func        = s_tuser;
  assign x_pos       = s_tdata[7:0];
  assign y_pos       = s_tdata[15:8];
  assign x_end       = s_tdata[23:16];
  assign y_end       = s_tdata[31:24];
  assign rect_width  = s_tdata[39:32];
  assign rect_height = s_tdata[47:40];
  assign color_in    = s_tdata[48];
  assign char_code   = s_tdata[56:49];
  assign text_col    = s_tdata[64:57];
  assign text_row    = s_tdata[72:65];
  assign read_index  = s_tdata[82:73];

  logic [2:0]  state;
  logic        clr_reply;
  logic [9:0]  clr_cnt;
  logic        is_char, is_pixel, color, empty, stat, hit;
  logic [6:0]  gidx;
  logic [2:0]  col;
  logic [7:0]  data;
  logic [8:0]  x_lo, x_cur, x_hi, y_lo, y_hi;
  logic [4:0]  pg_cur, pg_hi;
  logic [12:0] base;

  // The frame buffer, one port, registered read.
  logic [7:0] mem [STORE_DEPTH];
  logic       we, re;
  logic [9:0] waddr, raddr;
  logic [7:0] wdata, rdata;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  logic accept;
  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;

  // Bounding box, first state and flags for the command at the input.
  logic [2:0] cmd_state;
  logic [8:0] cmd_x_lo, cmd_x_hi, cmd_y_lo, cmd_y_hi;
  logic       cmd_empty, cmd_stat;
  logic [8:0] cell_x;

  always_comb begin
    cell_x    = {3'b0, text_col[5:0]} * 9'(CELL_WIDTH);
    cmd_state = S_SETUP;
    cmd_x_lo  = {1'b0, x_pos};
    cmd_x_hi  = {1'b0, x_pos};
    cmd_y_lo  = {1'b0, y_pos};
    cmd_y_hi  = {1'b0, y_pos};
    cmd_empty = 1'b0;
    cmd_stat  = 1'b0;
    unique case (func)
      F_CLEAR: begin
        cmd_state = S_CLR;
      end
      F_PIXEL: begin
      end
      F_HLINE: begin
        cmd_x_lo = {1'b0, (x_pos < x_end) ? x_pos : x_end};
        cmd_x_hi = {1'b0, (x_pos < x_end) ? x_end : x_pos};
      end
      F_VLINE: begin
        cmd_y_lo = {1'b0, (y_pos < y_end) ? y_pos : y_end};
        cmd_y_hi = {1'b0, (y_pos < y_end) ? y_end : y_pos};
      end
      F_RECT: begin
        cmd_empty = (rect_width == 8'd0) || (rect_height == 8'd0);
        cmd_x_hi  = {1'b0, x_pos} + {1'b0, rect_width} - 9'd1;
        cmd_y_hi  = {1'b0, y_pos} + {1'b0, rect_height} - 9'd1;
      end
      F_CHAR: begin
        if (32'(text_col) >= CELL_COLS || 32'(text_row) >= CELL_ROWS) begin
          cmd_empty = 1'b1;
          cmd_stat  = 1'b1;
        end
        cmd_x_lo = cell_x;
        cmd_x_hi = cell_x + 9'd5;
        cmd_y_lo = {1'b0, text_row[4:0], 3'b000};
        cmd_y_hi = {1'b0, text_row[4:0], 3'b111};
      end
      F_READ: begin
        cmd_state = S_RDW;
      end
      default: begin
        cmd_stat  = 1'b1;
        cmd_state = S_DONE;
      end
    endcase
  end

  // Byte under the walker: its index, which of its rows are covered, and the new bits.
  logic [12:0] idx;
  logic [7:0]  mask, val;
  logic        drop, adv;
  logic [7:0]  row;

  always_comb begin
    idx  = base + {4'b0, x_cur};
    drop = (idx[12:10] != 3'd0);
    for (int b = 0; b < 8; b++) begin
      row     = {pg_cur, 3'(b)};
      mask[b] = ({1'b0, row} >= y_lo) && ({1'b0, row} <= y_hi);
    end
    if (is_char) begin
      val = (col < 3'd5) ? glyph_col(gidx, col) : 8'h00;
    end else begin
      val = {8{color}};
    end
  end

  always_comb begin
    we    = 1'b0;
    re    = 1'b0;
    waddr = idx[9:0];
    raddr = idx[9:0];
    wdata = val;
    adv   = 1'b0;
    unique case (state)
      S_IDLE: begin
        re    = accept && (func == F_READ);
        raddr = read_index;
      end
      S_CLR: begin
        we    = 1'b1;
        waddr = clr_cnt;
        wdata = 8'h00;
      end
      S_STEP: begin
        if (drop) begin
          adv = 1'b1;
        end else if (mask == 8'hFF) begin
          we  = 1'b1;
          adv = 1'b1;
        end else begin
          re = 1'b1;
        end
      end
      S_MOD: begin
        we    = 1'b1;
        wdata = (rdata & ~mask) | (val & mask);
        adv   = 1'b1;
      end
      default: begin
      end
    endcase
  end

  logic [8:0] xh_c, yh_c;
  assign xh_c = (x_hi > XMAX) ? XMAX : x_hi;
  assign yh_c = (y_hi > YMAX) ? YMAX : y_hi;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_reply <= 1'b0;
      clr_cnt   <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      // The result register empties on its transfer unless a new result loads it.
      if (m_tvalid && m_tready && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            is_char   <= (func == F_CHAR);
            is_pixel  <= (func == F_PIXEL);
            color     <= color_in;
            stat      <= cmd_stat;
            empty     <= cmd_empty;
            hit       <= 1'b0;
            data      <= 8'h00;
            gidx      <= (char_code < FIRST_CODE || char_code > LAST_CODE) ? 7'd0 :
                         7'(char_code - FIRST_CODE);
            x_lo      <= cmd_x_lo;
            x_hi      <= cmd_x_hi;
            y_lo      <= cmd_y_lo;
            y_hi      <= cmd_y_hi;
            clr_cnt   <= '0;
            clr_reply <= (func == F_CLEAR);
            state     <= cmd_state;
          end
        end
        S_CLR: begin
          clr_cnt <= clr_cnt + 10'd1;
          if (clr_cnt == 10'(STORE_DEPTH - 1)) begin
            state     <= clr_reply ? S_DONE : S_IDLE;
            clr_reply <= 1'b0;
          end
        end
        S_SETUP: begin
          x_hi <= xh_c;
          y_hi <= yh_c;
          if (empty || (x_lo > xh_c) || (y_lo > yh_c)) begin
            state <= S_DONE;
          end else begin
            pg_cur <= y_lo[7:3];
            pg_hi  <= yh_c[7:3];
            base   <= 13'(y_lo[7:3] * DISP_WIDTH);
            x_cur  <= x_lo;
            col    <= 3'd0;
            state  <= S_STEP;
          end
        end
        S_STEP: begin
          if (!drop && mask == 8'hFF) begin
            hit <= 1'b1;
          end
          if (!drop && mask != 8'hFF) begin
            state <= S_MOD;
          end
        end
        S_MOD: begin
          hit <= 1'b1;
        end
        S_RDW: begin
          data  <= rdata;
          state <= S_DONE;
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {7'b0, stat | (is_pixel & ~hit), data};
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      // Walk columns across one page, then move down to the next page.
      if (adv) begin
        if (x_cur == x_hi) begin
          if (pg_cur == pg_hi) begin
            state <= S_DONE;
          end else begin
            pg_cur <= pg_cur + 5'd1;
            base   <= base + 13'(DISP_WIDTH);
            x_cur  <= x_lo;
            col    <= 3'd0;
            state  <= S_STEP;
          end
        end else begin
          x_cur <= x_cur + 9'd1;
          col   <= col + 3'd1;
          state <= S_STEP;
        end
      end
    end
  end

endmodule

// File: test/testbench.sv
module testbench;
  import mfb_pkg::*;

  localparam int W        = DISP_WIDTH_DEF;
  localparam int H        = DISP_HEIGHT_DEF;
  localparam int NCOLS    = CELL_COLS_DEF;
  localparam int NROWS    = CELL_ROWS_DEF;
  localparam int CW       = CELL_WIDTH_DEF;
  localparam int N_RANDOM = 1525;
  // Longest legal stretch without a transfer: a clear, the clearing pass after reset or a
  // screen-sized rectangle, each walking the whole buffer; this limit is many times that.
  localparam int STALL_LIMIT = 40000;

  // One drawing command: func travels on tuser, the rest on tdata in this bit order.
  typedef struct packed {
    logic [2:0] func;
    logic [4:0] pad;
    logic [9:0] read_index;
    logic [7:0] text_row;
    logic [7:0] text_col;
    logic [7:0] char_code;
    logic       color;
    logic [7:0] rect_height;
    logic [7:0] rect_width;
    logic [7:0] y_end;
    logic [7:0] x_end;
    logic [7:0] y_pos;
    logic [7:0] x_pos;
  } cmd_t;

  localparam logic [2:0] F_UNUSED = 3'd7;

  // Mirror of the frame buffer plus the queue of replies it predicts.
  class pixel_scoreboard;
    logic [7:0] frame [STORE_DEPTH];
    logic [8:0] replies [$];
    int errors;

    function new();
      foreach (frame[i]) frame[i] = 8'h00;
      errors = 0;
    endfunction

    function bit plot(int x, int y, logic on);
      int idx;
      if (x >= W || y >= H) return 0;
      idx = x + (y / 8) * W;
      if (idx >= STORE_DEPTH) return 0;
      frame[idx][y % 8] = on;
      return 1;
    endfunction

    function void span(int xa, int xb, int y, logic on);
      for (int x = xa; x <= xb && x < W; x++) void'(plot(x, y, on));
    endfunction

    function void glyph(int col, int row, int code);
      logic [39:0] g;
      logic [7:0] bits;
      // Anything outside the printable range is drawn as a blank.
      if (code < FIRST_CODE || code > LAST_CODE) code = int'(FIRST_CODE);
      g = GLYPH[code - FIRST_CODE];
      for (int c = 0; c < 5; c++) begin
        bits = g[39 - 8 * c -: 8];
        for (int b = 0; b < 8; b++) void'(plot(col * CW + c, row * 8 + b, bits[b]));
      end
      for (int b = 0; b < 8; b++) void'(plot(col * CW + 5, row * 8 + b, 1'b0));
    endfunction

    function void note_command(cmd_t c);
      logic [7:0] data;
      logic status;
      int lo, hi;
      data = 8'h00;
      status = 1'b0;
      case (c.func)
        F_CLEAR: foreach (frame[i]) frame[i] = 8'h00;
        F_PIXEL: status = !plot(int'(c.x_pos), int'(c.y_pos), c.color);
        F_HLINE: begin
          lo = int'((c.x_pos < c.x_end) ? c.x_pos : c.x_end);
          hi = int'((c.x_pos < c.x_end) ? c.x_end : c.x_pos);
          span(lo, hi, int'(c.y_pos), c.color);
        end
        F_VLINE: begin
          lo = int'((c.y_pos < c.y_end) ? c.y_pos : c.y_end);
          hi = int'((c.y_pos < c.y_end) ? c.y_end : c.y_pos);
          for (int y = lo; y <= hi && y < H; y++) void'(plot(int'(c.x_pos), y, c.color));
        end
        F_RECT: begin
          if (c.rect_width != 0 && c.rect_height != 0)
            for (int y = int'(c.y_pos); y < int'(c.y_pos) + int'(c.rect_height) && y < H; y++)
              span(int'(c.x_pos), int'(c.x_pos) + int'(c.rect_width) - 1, y, c.color);
        end
        F_CHAR: begin
          if (c.text_col >= NCOLS || c.text_row >= NROWS) status = 1'b1;
          else glyph(int'(c.text_col), int'(c.text_row), int'(c.char_code));
        end
        F_READ: data = frame[c.read_index];
        default: status = 1'b1;
      endcase
      replies.push_back({status, data});
    endfunction

    function void check_result(logic [15:0] got);
      logic [8:0] want;
      if (replies.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = replies.pop_front();
      if (got[7:0] !== want[7:0]) begin
        $display("%0t: read_data mismatch, expected %h, actual %h", $time, want[7:0], got[7:0]);
        errors++;
      end
      if (got[8] !== want[8]) begin
        $display("%0t: status mismatch, expected %b, actual %b", $time, want[8], got[8]);
        errors++;
      end
      if (got[15:9] !== 7'd0) begin
        $display("%0t: padding mismatch, expected 0, actual %h", $time, got[15:9]);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [87:0] s_tdata = '0;
  logic [2:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;

  pixel_scoreboard board = new();
  int  stall_cycles = 0;
  int  cycle_count = 0;
  bit  sender_steady = 0;

  mono_framebuffer_text_draw dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // The result side stalls at random, except for one long window where it never does.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst) begin
      m_tready <= 1'b0;
    end else if (cycle_count > 20000 && cycle_count < 30000) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(99) >= 18);
    end
  end

  // Both handshakes are observed here, with values as they stood before the edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) board.note_command(cmd_t'({s_tuser, s_tdata}));
      if (m_tvalid && m_tready) board.check_result(m_tdata);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("mono_framebuffer_text_draw verification failed");
    $finish;
  end

  // Hands one command over and returns at the edge where the transfer happens. A gap,
  // when one is drawn, comes before the command so that valid never drops and rises
  // in the same step.
  task automatic send_cmd(cmd_t c);
    if (!sender_steady && $urandom_range(99) < 18) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    s_tdata  <= c[87:0];
    s_tuser  <= c.func;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  function automatic cmd_t base_cmd(logic [2:0] f);
    cmd_t c;
    c = '0;
    c.func = f;
    return c;
  endfunction

  function automatic cmd_t rand_cmd();
    cmd_t c;
    int pick;
    c = cmd_t'(91'({$urandom(), $urandom(), $urandom()}));
    c.pad = '0;
    pick = $urandom_range(99);
    // Reads dominate so that drawing shows up in the results; clears stay rare
    // because each one wipes the picture and walks the whole buffer.
    if (pick < 35) c.func = F_READ;
    else if (pick < 50) c.func = F_PIXEL;
    else if (pick < 60) c.func = F_HLINE;
    else if (pick < 70) c.func = F_VLINE;
    else if (pick < 78) c.func = F_RECT;
    else if (pick < 96) c.func = F_CHAR;
    else if (pick < 98) c.func = F_UNUSED;
    else c.func = ($urandom_range(3) == 0) ? F_CLEAR : F_READ;
    if ($urandom_range(9) < 8) begin
      c.x_pos = 8'($urandom_range(W + 7));
      c.y_pos = 8'($urandom_range(H + 7));
      c.x_end = 8'($urandom_range(W + 7));
      c.y_end = 8'($urandom_range(H + 7));
      c.text_col = 8'($urandom_range(NCOLS + 1));
      c.text_row = 8'($urandom_range(NROWS + 1));
    end
    if ($urandom_range(9) < 8) begin
      c.rect_width  = 8'($urandom_range(24));
      c.rect_height = 8'($urandom_range(16));
    end
    if ($urandom_range(1) == 0) c.char_code = 8'($urandom_range(LAST_CODE, FIRST_CODE));
    return c;
  endfunction

  initial begin
    cmd_t c;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part: corners, clipping, reversed endpoints, empty rectangles,
    // glyph edge cases and the unused function code.
    c = base_cmd(F_PIXEL); c.color = 1'b1; send_cmd(c);
    c = base_cmd(F_PIXEL); c.x_pos = 8'(W - 1); c.y_pos = 8'(H - 1); c.color = 1'b1;
    send_cmd(c);
    c = base_cmd(F_PIXEL); c.x_pos = 8'(W); c.color = 1'b1; send_cmd(c);
    c = base_cmd(F_PIXEL); c.y_pos = 8'(H); c.color = 1'b1; send_cmd(c);
    c = base_cmd(F_PIXEL); c.x_pos = 8'hFF; c.y_pos = 8'hFF; c.color = 1'b1; send_cmd(c);
    c = base_cmd(F_READ); c.read_index = 10'd0; send_cmd(c);
    c = base_cmd(F_READ); c.read_index = 10'h3FF; send_cmd(c);
    c = base_cmd(F_HLINE); c.x_pos = 8'hFF; c.x_end = 8'd120; c.y_pos = 8'd9;
    c.color = 1'b1; send_cmd(c);
    c = base_cmd(F_VLINE); c.x_pos = 8'd3; c.y_pos = 8'hFF; c.y_end = 8'd60;
    c.color = 1'b1; send_cmd(c);
    c = base_cmd(F_RECT); c.rect_width = 8'd0; c.rect_height = 8'd5; c.color = 1'b1;
    send_cmd(c);
    c = base_cmd(F_RECT); c.rect_width = 8'd5; c.rect_height = 8'd0; c.color = 1'b1;
    send_cmd(c);
    c = base_cmd(F_RECT); c.x_pos = 8'd100; c.y_pos = 8'd50; c.rect_width = 8'hFF;
    c.rect_height = 8'hFF; c.color = 1'b1; send_cmd(c);
    c = base_cmd(F_RECT); c.x_pos = 8'd110; c.y_pos = 8'd55; c.rect_width = 8'd4;
    c.rect_height = 8'd3; c.color = 1'b0; send_cmd(c);
    c = base_cmd(F_CHAR); c.char_code = "A"; send_cmd(c);
    c = base_cmd(F_CHAR); c.char_code = 8'h1F; c.text_col = 8'd1; send_cmd(c);
    c = base_cmd(F_CHAR); c.char_code = 8'hFF; c.text_col = 8'd2; send_cmd(c);
    c = base_cmd(F_CHAR); c.char_code = LAST_CODE; c.text_col = 8'(NCOLS - 1);
    c.text_row = 8'(NROWS - 1); send_cmd(c);
    c = base_cmd(F_CHAR); c.char_code = "B"; c.text_col = 8'(NCOLS); send_cmd(c);
    c = base_cmd(F_CHAR); c.char_code = "C"; c.text_row = 8'(NROWS); send_cmd(c);
    c = base_cmd(F_READ); c.read_index = 10'd6; send_cmd(c);
    c = base_cmd(F_READ); c.read_index = 10'(7 * W + (NCOLS - 1) * CW + 2); send_cmd(c);
    c = base_cmd(F_UNUSED); send_cmd(c);
    c = base_cmd(F_CLEAR); c.color = 1'b1; send_cmd(c);
    c = base_cmd(F_READ); c.read_index = 10'h3FF; send_cmd(c);

    // Let the block drain completely once before the random traffic.
    s_tvalid <= 1'b0;
    while (board.replies.size() != 0) @(posedge clk);

    for (int i = 0; i < N_RANDOM; i++) begin
      sender_steady = (i >= 600 && i < 900);
      send_cmd(rand_cmd());
    end
    s_tvalid <= 1'b0;

    while (board.replies.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (board.errors == 0) begin
      $display("mono_framebuffer_text_draw verification clean");
    end else begin
      $display("mono_framebuffer_text_draw verification failed");
    end
    $finish;
  end
endmodule
